// ===== src/pmdu_pkg.sv =====
`default_nettype none
package pmdu_pkg;

	localparam int MAX_DATA_FIELD_DEF = 255;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 9;
	localparam int CHUNK_W  = 64;
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_STREAM_PACKET_ID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_FIELD_BYTES = 1'b1;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// packet being streamed out
	typedef struct packed {
		logic [BYTE_W-1:0] header;
		logic              pad;
		logic [BYTE_W-1:0] used;
		logic [BYTE_W-1:0] len;
	} pkt_desc_t;

	// position handed to the read stage
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] pos;
	} issue_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [BYTE_W-1:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/pmdu_byte_if.sv =====
`default_nettype none
interface pmdu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_unit;

	modport source (output valid, output data_byte, output end_of_unit, input ready);
	modport sink (input valid, input data_byte, input end_of_unit, output ready);
endinterface
`default_nettype wire

// ===== src/pmdu_chunk_if.sv =====
`default_nettype none
interface pmdu_chunk_if;
	logic        valid;
	logic        ready;
	logic [63:0] chunk;
	logic [3:0]  chunk_bytes;
	logic        end_of_packet;

	modport source (output valid, output chunk, output chunk_bytes, output end_of_packet,
		input ready);
	modport sink (input valid, input chunk, input chunk_bytes, input end_of_packet,
		output ready);
endinterface
`default_nettype wire

// ===== src/packet_mode_data_unit_encoder.sv =====
`default_nettype none
// Packet-mode data unit encoder. Bytes of a data unit come in on the data
// channel, one word per cycle, with end_of_unit on the last byte; they are
// stored in a packet buffer memory. When the buffer holds one data field or the
// unit ends, the packet (header, data field with count byte and zero padding if
// short, CRC-16 x16+x12+x5+1 preset FFFF and inverted) leaves on the chunks
// channel as big-endian words of up to eight bytes, end_of_packet on the word
// with the last CRC byte. Bytes are taken at one per cycle until a packet
// closes; the data channel then stays not ready while the packet is read
// out of the buffer memory, one byte per cycle through its single read port
// unless the chunks channel stalls. Configuration (index 0 stream_packet_id,
// index 1 data_field_bytes) is written via cfg_we, cfg_index and cfg_data; the
// user must write it only while the block is idle, which it does not enforce.
// A new packet id restarts the continuity index. No clearing pass after reset.
module packet_mode_data_unit_encoder #(
	parameter int MAX_DATA_FIELD = pmdu_pkg::MAX_DATA_FIELD_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pmdu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pmdu_pkg::CFG_DATA_W-1:0] cfg_data,
	pmdu_byte_if.sink                            data,
	pmdu_chunk_if.source                         chunks
);
	import pmdu_pkg::*;

	localparam int AW = (MAX_DATA_FIELD > 1) ? $clog2(MAX_DATA_FIELD) : 1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          advance;
	logic          done;
	pkt_desc_t     desc;
	issue_t        issue;

	pmdu_ctrl #(
		.MAX_DATA_FIELD (MAX_DATA_FIELD),
		.AW             (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data      (data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.desc      (desc),
		.issue     (issue),
		.advance   (advance),
		.done      (done)
	);

	pmdu_buffer #(
		.DEPTH (MAX_DATA_FIELD),
		.AW    (AW)
	) u_buffer (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (advance),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pmdu_asm u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.desc    (desc),
		.issue   (issue),
		.rd_data (rd_data),
		.advance (advance),
		.done    (done),
		.chunks  (chunks)
	);
endmodule
`default_nettype wire

// ===== src/pmdu_buffer.sv =====
`default_nettype none
module pmdu_buffer #(
	parameter int DEPTH = 255,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [7:0]         rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds while the read stage is stalled
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

// ===== src/pmdu_ctrl.sv =====
`default_nettype none
module pmdu_ctrl #(
	parameter int MAX_DATA_FIELD = 255,
	parameter int AW             = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pmdu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pmdu_pkg::CFG_DATA_W-1:0] cfg_data,
	pmdu_byte_if.sink                        data,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic [7:0]                       wr_data,
	output logic [AW-1:0]                    rd_addr,
	output pmdu_pkg::pkt_desc_t              desc,
	output pmdu_pkg::issue_t                 issue,
	input  wire logic                        advance,
	input  wire logic                        done
);
	import pmdu_pkg::*;

	localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_DATA_FIELD);

	logic [1:0]        pkt_id_q;
	logic [7:0]        dfb_q;
	logic [BYTE_W-1:0] fill_q;
	logic              start_q;
	logic [2:0]        ci_q;
	logic              busy_q;
	logic              issuing_q;
	logic [POS_W-1:0]  pos_q;
	pkt_desc_t         desc_q;

	logic [BYTE_W-1:0] len_eff;
	logic              acc;
	logic              fill_lt;
	logic [BYTE_W-1:0] fill_new;
	logic              trigger;
	logic [BYTE_W-1:0] used;
	logic              pad;
	logic [POS_W-1:0]  last_pos;

	always_comb begin
		priority if (dfb_q == '0) begin
			len_eff = BYTE_W'(1);
		end else if (dfb_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = dfb_q;
		end
	end

	assign data.ready = !busy_q;
	assign acc        = data.valid && data.ready;
	assign fill_lt    = fill_q < len_eff;
	assign fill_new   = fill_lt ? fill_q + BYTE_W'(1) : fill_q;
	assign trigger    = acc && ((fill_new >= len_eff) || data.end_of_unit);
	assign used       = (fill_new < len_eff) ? fill_new : len_eff;
	assign pad        = used < len_eff;

	assign wr_en   = acc && fill_lt;
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = data.data_byte;

	// padded packets carry the count byte ahead of the data
	assign rd_addr = desc_q.pad ? AW'(pos_q - POS_W'(2)) : AW'(pos_q - POS_W'(1));

	assign last_pos    = POS_W'(desc_q.len) + POS_W'(2);
	assign desc        = desc_q;
	assign issue.valid = issuing_q;
	assign issue.pos   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_id_q  <= '0;
			dfb_q     <= 8'hFF;
			fill_q    <= '0;
			start_q   <= 1'b1;
			ci_q      <= '0;
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			pos_q     <= '0;
		end else begin
			if (trigger) begin
				fill_q    <= '0;
				ci_q      <= ci_q + 3'd1;
				start_q   <= data.end_of_unit;
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				pos_q     <= '0;
			end else if (acc) begin
				fill_q <= fill_new;
			end
			if (issuing_q && advance) begin
				if (pos_q == last_pos) begin
					issuing_q <= 1'b0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (done) begin
				busy_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STREAM_PACKET_ID: begin
						if (cfg_data[1:0] != pkt_id_q) begin
							ci_q <= '0;
						end
						pkt_id_q <= cfg_data[1:0];
					end
					REG_DATA_FIELD_BYTES: begin
						dfb_q <= cfg_data;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trigger) begin
			desc_q.header <= {start_q, data.end_of_unit, pkt_id_q, pad, ci_q};
			desc_q.pad    <= pad;
			desc_q.used   <= used;
			desc_q.len    <= len_eff;
		end
	end
endmodule
`default_nettype wire

// ===== src/pmdu_asm.sv =====
`default_nettype none
module pmdu_asm (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pmdu_pkg::pkt_desc_t desc,
	input  wire pmdu_pkg::issue_t    issue,
	input  wire logic [7:0]     rd_data,
	output logic                advance,
	output logic                done,
	pmdu_chunk_if.source        chunks
);
	import pmdu_pkg::*;

	logic              valid_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [15:0]       crc_q;
	logic [CHUNK_W-1:0] acc_q;
	logic [2:0]        acc_n_q;
	logic              out_valid_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [CNT_W-1:0]  bytes_q;
	logic              eop_q;

	logic [POS_W-1:0]  len9;
	logic [POS_W-1:0]  used9;
	logic [BYTE_W-1:0] b;
	logic              in_field;
	logic              last;
	logic              flush;
	logic              stall;
	logic              step;
	logic [CHUNK_W-1:0] acc_next;
	logic [15:0]       crc_out;

	assign len9    = POS_W'(desc.len);
	assign used9   = POS_W'(desc.used);
	assign crc_out = ~crc_q;

	always_comb begin
		priority if (pos_s1 == '0) begin
			b = desc.header;
		end else if (pos_s1 <= len9) begin
			if (desc.pad) begin
				priority if (pos_s1 == POS_W'(1)) begin
					b = desc.used;
				end else if (pos_s1 <= used9 + POS_W'(1)) begin
					b = rd_data;
				end else begin
					b = '0;
				end
			end else begin
				b = rd_data;
			end
		end else if (pos_s1 == len9 + POS_W'(1)) begin
			b = crc_out[15:8];
		end else begin
			b = crc_out[7:0];
		end
	end

	assign in_field = pos_s1 <= len9;
	assign last     = pos_s1 == len9 + POS_W'(2);
	assign flush    = (acc_n_q == 3'd7) || last;
	assign stall    = valid_s1 && flush && out_valid_q && !chunks.ready;
	assign advance  = !stall;
	assign step     = valid_s1 && advance;
	assign done     = step && last;
	// new byte lands just below the bytes already gathered
	assign acc_next = acc_q | ({b, {(CHUNK_W-BYTE_W){1'b0}}} >> {acc_n_q, 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_n_q     <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= issue.valid;
			end
			if (step && flush) begin
				out_valid_q <= 1'b1;
			end else if (chunks.ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				if (flush) begin
					acc_q   <= '0;
					acc_n_q <= '0;
				end else begin
					acc_q   <= acc_next;
					acc_n_q <= acc_n_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pos_s1 <= issue.pos;
		end
		if (step && in_field) begin
			crc_q <= crc16_byte((pos_s1 == '0) ? CRC_INIT : crc_q, b);
		end
		if (step && flush) begin
			chunk_q <= acc_next;
			bytes_q <= CNT_W'(acc_n_q) + CNT_W'(1);
			eop_q   <= last;
		end
	end

	assign chunks.valid         = out_valid_q;
	assign chunks.chunk         = chunk_q;
	assign chunks.chunk_bytes   = bytes_q;
	assign chunks.end_of_packet = eop_q;
endmodule
`default_nettype wire

// ===== sim/packet_mode_data_unit_encoder_tb.sv =====
module packet_mode_data_unit_encoder_tb;
	import pmdu_pkg::*;

	localparam int MAX_FIELD     = MAX_DATA_FIELD_DEF;
	localparam int SETTLE_CYCLES = MAX_FIELD + 8;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 500;
	localparam int REPORT_CAP    = 40;

	typedef struct packed {
		logic [7:0] b;
		logic       eou;
	} in_word_t;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        eop;
	} chunk_t;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_SET_ID,
		ROW_SET_LEN
	} row_kind_t;

	// exp_words and hdr are typed in by hand
	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] val;
		logic       eou;
		logic [5:0] exp_words;
		logic [7:0] hdr;
	} stim_row_t;

	localparam int N_ROWS = 27;
	localparam stim_row_t STIM_ROWS [0:N_ROWS-1] = '{
		'{ROW_BYTE,    8'h00, 1'b1, 6'd33, 8'hC8},
		'{ROW_BYTE,    8'hFF, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'hA5, 1'b1, 6'd33, 8'hC9},
		'{ROW_SET_ID,  8'h03, 1'b0, 6'd0,  8'h00},
		'{ROW_SET_LEN, 8'd1,  1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h5A, 1'b0, 6'd1,  8'hB0},
		'{ROW_BYTE,    8'h3C, 1'b1, 6'd1,  8'h71},
		// same id again, upper bits set: continuity keeps counting
		'{ROW_SET_ID,  8'hFF, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h81, 1'b1, 6'd1,  8'hF2},
		// zero length behaves as one
		'{ROW_SET_LEN, 8'd0,  1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h7E, 1'b1, 6'd1,  8'hF3},
		'{ROW_SET_LEN, 8'd4,  1'b0, 6'd0,  8'h00},
		'{ROW_SET_ID,  8'h01, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h01, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h02, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h03, 1'b0, 6'd0,  8'h00},
		// unit ends exactly on a full packet
		'{ROW_BYTE,    8'h04, 1'b1, 6'd1,  8'hD0},
		'{ROW_BYTE,    8'h10, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h20, 1'b1, 6'd1,  8'hD9},
		'{ROW_SET_LEN, 8'd8,  1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h11, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h22, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h33, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h44, 1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h55, 1'b0, 6'd0,  8'h00},
		// shrink below the fill: next byte dropped, first three go out
		'{ROW_SET_LEN, 8'd3,  1'b0, 6'd0,  8'h00},
		'{ROW_BYTE,    8'h66, 1'b0, 6'd1,  8'h92}
	};

	localparam int N_PHASES = 11;
	localparam logic [7:0] PHASE_LEN [0:N_PHASES-1] = '{
		8'd2, 8'd8, 8'd1, 8'd3, 8'd255, 8'd5, 8'd16, 8'd0, 8'd7, 8'd40, 8'd4
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pmdu_byte_if  byte_bus ();
	pmdu_chunk_if chunk_bus ();

	packet_mode_data_unit_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.data      (byte_bus),
		.chunks    (chunk_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// encoder state as the predictor sees it
	logic [7:0] held_bytes [0:MAX_FIELD-1];
	int         held_count;
	bit         unit_opening;
	logic [2:0] cont_idx;
	logic [1:0] pid_reg;
	logic [7:0] field_len_reg;

	chunk_t   chunks_due [$];
	in_word_t send_q [$];
	int       pending_in;
	int       err_count;
	int       gap_max;
	int       idle_cycles;
	bit       hold_req;

	task automatic report_mismatch(input string what);
		if (err_count < REPORT_CAP) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		err_count++;
	endtask

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [7:0] val);
		if (idx == REG_STREAM_PACKET_ID) begin
			if (val[1:0] != pid_reg) begin
				cont_idx = '0;
			end
			pid_reg = val[1:0];
		end else begin
			field_len_reg = val;
		end
	endfunction

	// takes one input byte, queues the chunks of the packet it closes, if any
	function automatic int encode_byte(input logic [7:0] b, input logic eou);
		logic [7:0]  pkt [0:MAX_FIELD+2];
		logic [15:0] crc;
		logic [63:0] w;
		int          len;
		int          used;
		int          total;
		int          n;
		int          words;
		len = (field_len_reg == 8'd0) ? 1 : int'(field_len_reg);
		if (held_count < len) begin
			held_bytes[held_count] = b;
			held_count++;
		end
		if (held_count < len && !eou) begin
			return 0;
		end
		used = (held_count < len) ? held_count : len;
		pkt[0] = {unit_opening, eou, pid_reg, (used < len), cont_idx};
		total = 1;
		if (used < len) begin
			pkt[total++] = used[7:0];
			for (int i = 0; i < used; i++) begin
				pkt[total++] = held_bytes[i];
			end
			for (int i = used + 1; i < len; i++) begin
				pkt[total++] = 8'h00;
			end
		end else begin
			for (int i = 0; i < len; i++) begin
				pkt[total++] = held_bytes[i];
			end
		end
		crc = CRC_INIT;
		for (int i = 0; i < total; i++) begin
			crc = crc16_next(crc, pkt[i]);
		end
		crc = ~crc;
		pkt[total++] = crc[15:8];
		pkt[total++] = crc[7:0];
		cont_idx = cont_idx + 3'd1;
		held_count = 0;
		unit_opening = eou;
		words = 0;
		for (int pos = 0; pos < total; pos += 8) begin
			n = (total - pos > 8) ? 8 : total - pos;
			w = '0;
			for (int i = 0; i < 8; i++) begin
				w = {w[55:0], (i < n) ? pkt[pos + i] : 8'h00};
			end
			chunks_due.push_back('{data: w, nbytes: n[3:0], eop: (pos + n == total)});
			words++;
		end
		return words;
	endfunction

	function automatic int offer_byte(input logic [7:0] b, input logic eou);
		send_q.push_back('{b: b, eou: eou});
		pending_in++;
		return encode_byte(b, eou);
	endfunction

	// registers only change with nothing in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		wait (pending_in == 0 && chunks_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		note_reg_write(idx, val);
	endtask

	// sender: bursts of words with random gaps
	initial begin : byte_driver
		in_word_t nxt;
		int       burst_left;
		int       gap_left;
		burst_left = 0;
		gap_left = 0;
		byte_bus.valid <= 1'b0;
		byte_bus.data_byte <= '0;
		byte_bus.end_of_unit <= 1'b0;
		forever begin
			@(posedge clk);
			if (byte_bus.valid && byte_bus.ready) begin
				pending_in--;
			end
			if (!byte_bus.valid || byte_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_bus.valid <= 1'b0;
				end else if (send_q.size() > 0) begin
					nxt = send_q.pop_front();
					byte_bus.data_byte <= nxt.b;
					byte_bus.end_of_unit <= nxt.eou;
					byte_bus.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
					end
				end else begin
					byte_bus.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: rotating stall pattern, plus one long hold on request
	initial begin : chunk_sink
		logic [7:0] pat;
		int         pat_age;
		int         hold_left;
		pat = 8'hFF;
		pat_age = 0;
		hold_left = 0;
		chunk_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				chunk_bus.ready <= 1'b0;
			end else begin
				if (pat_age == 0) begin
					pat_age = $urandom_range(20, 80);
					pat = ($urandom_range(0, 3) == 0) ? 8'hFF :
						(8'($urandom_range(0, 255)) | 8'h01);
				end
				pat_age--;
				chunk_bus.ready <= pat[0];
				pat = {pat[0], pat[7:1]};
			end
		end
	end

	always @(posedge clk) begin : chunk_check
		chunk_t due;
		if (arst_n && chunk_bus.valid && chunk_bus.ready) begin
			if (chunks_due.size() == 0) begin
				report_mismatch($sformatf("word %h with nothing expected", chunk_bus.chunk));
			end else begin
				due = chunks_due.pop_front();
				if (chunk_bus.chunk !== due.data) begin
					report_mismatch($sformatf("chunk %h, expected %h", chunk_bus.chunk, due.data));
				end
				if (chunk_bus.chunk_bytes !== due.nbytes) begin
					report_mismatch($sformatf("chunk_bytes %0d, expected %0d",
						chunk_bus.chunk_bytes, due.nbytes));
				end
				if (chunk_bus.end_of_packet !== due.eop) begin
					report_mismatch($sformatf("end_of_packet %b, expected %b",
						chunk_bus.end_of_packet, due.eop));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_bus.valid && byte_bus.ready) ||
				(chunk_bus.valid && chunk_bus.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", idle_cycles);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int n;
		int eff;
		int budget;
		int sent;
		int ulen;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_cycles = 0;
		err_count = 0;
		pending_in = 0;
		hold_req = 1'b0;
		gap_max = 3;
		held_count = 0;
		unit_opening = 1'b1;
		cont_idx = '0;
		pid_reg = '0;
		field_len_reg = 8'd255;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			case (STIM_ROWS[r].kind)
				ROW_SET_ID: begin
					write_reg(REG_STREAM_PACKET_ID, STIM_ROWS[r].val);
				end
				ROW_SET_LEN: begin
					write_reg(REG_DATA_FIELD_BYTES, STIM_ROWS[r].val);
				end
				default: begin
					n = offer_byte(STIM_ROWS[r].val, STIM_ROWS[r].eou);
					if (n != STIM_ROWS[r].exp_words) begin
						report_mismatch($sformatf("row %0d: %0d words predicted, %0d typed",
							r, n, STIM_ROWS[r].exp_words));
					end else if (n > 0 &&
							chunks_due[chunks_due.size() - n].data[63:56] != STIM_ROWS[r].hdr) begin
						report_mismatch($sformatf("row %0d: header %h predicted, %h typed", r,
							chunks_due[chunks_due.size() - n].data[63:56], STIM_ROWS[r].hdr));
					end
				end
			endcase
		end
		// short final packet after the shrink
		void'(offer_byte(8'h77, 1'b1));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			gap_max = (ph % 3 == 1) ? 0 : $urandom_range(2, 8);
			if (ph == 0) begin
				write_reg(REG_STREAM_PACKET_ID, {6'($urandom_range(0, 63)), 2'd2});
			end else if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_STREAM_PACKET_ID, 8'($urandom_range(0, 255)));
			end
			write_reg(REG_DATA_FIELD_BYTES, PHASE_LEN[ph]);
			// receiver holds off while bytes keep coming, so the input backs up
			if (ph == 1) begin
				hold_req = 1'b1;
			end
			eff = (PHASE_LEN[ph] == 8'd0) ? 1 : int'(PHASE_LEN[ph]);
			budget = (eff == MAX_FIELD) ? MAX_FIELD + 1 : $urandom_range(15, 25);
			sent = 0;
			while (sent < budget) begin
				ulen = (eff == MAX_FIELD) ? MAX_FIELD + 1 : $urandom_range(1, 3 * eff + 1);
				for (int k = 0; k < ulen && sent < budget; k++) begin
					void'(offer_byte(8'($urandom_range(0, 255)), k == ulen - 1));
					sent++;
				end
			end
		end

		wait (pending_in == 0 && chunks_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/pmdu_pkg.sv
src/pmdu_byte_if.sv
src/pmdu_chunk_if.sv
src/pmdu_buffer.sv
src/pmdu_ctrl.sv
src/pmdu_asm.sv
src/packet_mode_data_unit_encoder.sv
sim/packet_mode_data_unit_encoder_tb.sv
